FILE: hw/rtl/zbpe_pkg.sv
// ============================================================================
// Z-buffer plot engine package
// Shared widths, codes, controller states and control structs.
// ============================================================================
package zbpe_pkg;

   // Field widths.
   localparam int COORD_W = 18;
   localparam int DEPTH_W = 32;
   localparam int GLYPH_W = 8;
   localparam int INDEX_W = 14;
   localparam int COLS_W  = 9;
   localparam int ROWS_W  = 7;
   localparam int FRAC_W  = 16;
   localparam int OP_W    = 2;

   // Largest values the column and row registers can hold.
   localparam int COLS_MAX = (2 ** COLS_W) - 1;
   localparam int ROWS_MAX = (2 ** ROWS_W) - 1;

   // Default store geometry.
   localparam int MAX_COLUMNS_DEFAULT = 256;
   localparam int MAX_ROWS_DEFAULT    = 64;

   // Register reset values.
   localparam logic [COLS_W-1:0] COLUMNS_RESET = COLS_W'(80);
   localparam logic [ROWS_W-1:0] ROWS_RESET    = ROWS_W'(24);

   // Values written by a clear.
   localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'h20;
   localparam logic [DEPTH_W-1:0] CLEAR_DEPTH = '0;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COLS_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 2'd1;

   // Request payload layout, lowest bit first.
   localparam int REQ_X_LSB     = 0;
   localparam int REQ_Y_LSB     = REQ_X_LSB + COORD_W;
   localparam int REQ_DEPTH_LSB = REQ_Y_LSB + COORD_W;
   localparam int REQ_GLYPH_LSB = REQ_DEPTH_LSB + DEPTH_W;
   localparam int REQ_INDEX_LSB = REQ_GLYPH_LSB + GLYPH_W;
   localparam int REQ_USED_W    = REQ_INDEX_LSB + INDEX_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_PLOT  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SCALE,
      S_BOUND,
      S_CELL,
      S_DEPTH_RD,
      S_DEPTH_TEST,
      S_GLYPH_RD,
      S_GLYPH_TAKE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic bound;
      logic address;
      logic depth_rd;
      logic depth_test;
      logic glyph_rd;
      logic glyph_take;
      logic clear_wr;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/zbuffer_plot_engine.sv
// The engine takes one transaction at a time; the controller steps a plot through
// scale, bound, address, depth read and test, and a read through glyph read and take.
// The clear sweep writes one cell per cycle through the single frame memory port.
// Reset is synchronous and active high; it restores 80 columns and 24 rows and
// empties the output register; frame memories hold no defined contents until a clear.
// ============================================================================
// Z-buffer plot engine
// Character frame with a per-cell depth buffer: clear, depth-tested plot and read.
// ============================================================================
module zbuffer_plot_engine
   import zbpe_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // req_tdata fields from bit 0: point_x[17:0], point_y[35:18],
   // point_depth[67:36], glyph[75:68], cell_index[89:76], zero pad.
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser fields from bit 0: operation[1:0].
   input  logic [OP_W-1:0]        req_tuser,
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // rsp_tdata fields from bit 0: glyph_out[7:0].
   output logic [GLYPH_W-1:0]     rsp_tdata,
   // rsp_tuser fields from bit 0: written[0].
   output logic [0:0]             rsp_tuser,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          rsp_written;

   // Register writes always succeed; the user must write only while engine is idle.
   assign csr_ready = 1'b1;

   // The controller only moves one transaction at a time and never overwrites a
   // result that the consumer has not taken yet.
   zbpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the configuration, the scaling arithmetic, both frame
   // memories and the output register.
   zbpe_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .point_x     ($signed(req_tdata[REQ_X_LSB +: COORD_W])),
      .point_y     ($signed(req_tdata[REQ_Y_LSB +: COORD_W])),
      .point_depth ($signed(req_tdata[REQ_DEPTH_LSB +: DEPTH_W])),
      .glyph       (req_tdata[REQ_GLYPH_LSB +: GLYPH_W]),
      .cell_index  (req_tdata[REQ_INDEX_LSB +: INDEX_W]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_written (rsp_written),
      .rsp_glyph   (rsp_tdata)
   );

   assign rsp_tuser = rsp_written;

`ifndef SYNTHESIS
   // An accepted transaction leaves the engine busy in the cycle after it.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one was still in work");

   // A finished result never lands on top of one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending response");

   // The controller issues at most one datapath step per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scale, cmd.bound, cmd.address, cmd.depth_rd,
                cmd.depth_test, cmd.glyph_rd, cmd.glyph_take, cmd.clear_wr,
                cmd.finish}))
      else $error("more than one datapath step in one cycle");
`endif

endmodule

FILE: hw/rtl/zbpe_ctrl.sv
// ============================================================================
// Z-buffer plot engine controller
// Sequences one transaction at a time through the datapath steps.
// ============================================================================
module zbpe_ctrl
   import zbpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [OP_W-1:0]     req_op,
   output logic                req_tready,
   input  dp_status_type       status,
   output dp_cmd_type          cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (op_type'(req_op))
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_PLOT:  state_in = S_SCALE;
                  OP_READ:  state_in = S_GLYPH_RD;
                  default:  state_in = S_FINISH;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = S_FINISH;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_BOUND;
         end
         S_BOUND: begin
            cmd.bound = 1'b1;
            state_in  = S_CELL;
         end
         S_CELL: begin
            cmd.address = 1'b1;
            state_in    = S_DEPTH_RD;
         end
         S_DEPTH_RD: begin
            cmd.depth_rd = 1'b1;
            state_in     = S_DEPTH_TEST;
         end
         S_DEPTH_TEST: begin
            cmd.depth_test = 1'b1;
            state_in       = S_FINISH;
         end
         S_GLYPH_RD: begin
            cmd.glyph_rd = 1'b1;
            state_in     = S_GLYPH_TAKE;
         end
         S_GLYPH_TAKE: begin
            cmd.glyph_take = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/zbpe_datapath.sv
// ============================================================================
// Z-buffer plot engine datapath
// Configuration, point scaling, depth test, frame memories and result register.
// ============================================================================
module zbpe_datapath
   import zbpe_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = MAX_ROWS_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic signed [COORD_W-1:0]  point_x,
   input  logic signed [COORD_W-1:0]  point_y,
   input  logic signed [DEPTH_W-1:0]  point_depth,
   input  logic [GLYPH_W-1:0]         glyph,
   input  logic [INDEX_W-1:0]         cell_index,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic                       rsp_written,
   output logic [GLYPH_W-1:0]         rsp_glyph
);

   localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
   localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int PX_W       = COORD_W + COLS_W + 1;
   localparam int PY_W       = COORD_W + ROWS_W + 1;
   localparam int QX_W       = PX_W - FRAC_W;
   localparam int QY_W       = PY_W - FRAC_W;
   localparam int CELL_W     = COLS_W + ROWS_W + 1;

   localparam logic [COLS_W-1:0] COL_CAP =
      COLS_W'((MAX_COLUMNS > COLS_MAX) ? COLS_MAX : MAX_COLUMNS);
   localparam logic [ROWS_W-1:0] ROW_CAP =
      ROWS_W'((MAX_ROWS > ROWS_MAX) ? ROWS_MAX : MAX_ROWS);

   // Configuration registers.
   logic [COLS_W-1:0] columns_ff, columns_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_valid && (csr_index == CSR_COLUMNS)) begin
         columns_in = csr_data;
      end
      if (csr_valid && (csr_index == CSR_ROWS)) begin
         rows_in = csr_data[ROWS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   // Screen size in effect: zero counts as one, and the store bounds the rest.
   logic [COLS_W-1:0] cols_eff;
   logic [ROWS_W-1:0] rows_eff;

   always_comb begin
      priority if (columns_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (columns_ff > COL_CAP) begin
         cols_eff = COL_CAP;
      end else begin
         cols_eff = columns_ff;
      end
      priority if (rows_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (rows_ff > ROW_CAP) begin
         rows_eff = ROW_CAP;
      end else begin
         rows_eff = rows_ff;
      end
   end

   // Transaction capture.
   logic [COLS_W-1:0]         span_cols_ff;
   logic [ROWS_W-1:0]         span_rows_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic signed [DEPTH_W-1:0] pz_ff;
   logic [GLYPH_W-1:0]        glyph_ff;
   logic [INDEX_W-1:0]        idx_ff;
   logic [AW-1:0]             clr_end_ff;
   logic [CELL_W-1:0]         clr_total;

   assign clr_total = CELL_W'(cols_eff) * CELL_W'(rows_eff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         span_cols_ff <= cols_eff;
         span_rows_ff <= rows_eff;
         px_ff        <= point_x;
         py_ff        <= point_y;
         pz_ff        <= point_depth;
         glyph_ff     <= glyph;
         idx_ff       <= cell_index;
         clr_end_ff   <= AW'(clr_total - CELL_W'(1));
      end
   end

   // Scaling products.
   logic signed [PX_W-1:0] prod_x_ff;
   logic signed [PY_W-1:0] prod_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         prod_x_ff <= PX_W'(px_ff) * PX_W'($signed({1'b0, span_cols_ff}));
         prod_y_ff <= PY_W'(py_ff) * PY_W'($signed({1'b0, span_rows_ff}));
      end
   end

   // Truncation toward zero: bias negative products before the shift.
   logic signed [PX_W-1:0] sum_x;
   logic signed [PY_W-1:0] sum_y;
   logic signed [QX_W-1:0] qx;
   logic signed [QY_W-1:0] qy;
   logic                   col_ok, row_ok;

   assign sum_x = prod_x_ff + $signed({{(PX_W-FRAC_W){1'b0}}, {FRAC_W{prod_x_ff[PX_W-1]}}});
   assign sum_y = prod_y_ff + $signed({{(PY_W-FRAC_W){1'b0}}, {FRAC_W{prod_y_ff[PY_W-1]}}});
   assign qx    = sum_x[PX_W-1:FRAC_W];
   assign qy    = sum_y[PY_W-1:FRAC_W];
   assign col_ok = !qx[QX_W-1] && ($unsigned(qx) < QX_W'(span_cols_ff));
   assign row_ok = !qy[QY_W-1] && ($unsigned(qy) < QY_W'(span_rows_ff));

   logic [COLS_W-1:0] col_ff;
   logic [ROWS_W-1:0] row_ff;
   logic              inb_ff;

   always_ff @(posedge clock) begin
      if (cmd.bound) begin
         col_ff <= qx[COLS_W-1:0];
         row_ff <= qy[ROWS_W-1:0];
         inb_ff <= col_ok && row_ok;
      end
   end

   // Row-major cell address.
   logic [CELL_W-1:0] cell_sum;
   logic [AW-1:0]     cell_addr_ff;
   logic              cell_ok_ff;

   assign cell_sum = CELL_W'(row_ff) * CELL_W'(span_cols_ff) + CELL_W'(col_ff);

   always_ff @(posedge clock) begin
      if (cmd.address) begin
         cell_addr_ff <= AW'(cell_sum);
         cell_ok_ff   <= inb_ff && (int'(cell_sum) < CELL_COUNT);
      end
   end

   // Clear sweep counter.
   logic [AW-1:0] clr_count_ff, clr_count_in;

   always_comb begin
      clr_count_in = clr_count_ff;
      if (cmd.load) begin
         clr_count_in = '0;
      end else if (cmd.clear_wr) begin
         clr_count_in = clr_count_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      clr_count_ff <= clr_count_in;
   end

   // Frame memories: one address per cycle, registered read data.
   logic [GLYPH_W-1:0] glyph_mem [CELL_COUNT];
   logic [DEPTH_W-1:0] depth_mem [CELL_COUNT];
   logic [AW-1:0]      mem_addr;
   logic [AW-1:0]      idx_addr;
   logic               idx_ok;
   logic signed [DEPTH_W-1:0] depth_q_ff;
   logic [GLYPH_W-1:0] glyph_q_ff;
   logic               hit;
   logic               mem_we;
   logic [GLYPH_W-1:0] glyph_wdata;
   logic [DEPTH_W-1:0] depth_wdata;

   assign idx_addr = AW'(idx_ff);
   assign idx_ok   = int'(idx_ff) < CELL_COUNT;
   assign hit      = cmd.depth_test && cell_ok_ff && (depth_q_ff < pz_ff);
   assign mem_we   = cmd.clear_wr || hit;

   always_comb begin
      priority if (cmd.clear_wr) begin
         mem_addr    = clr_count_ff;
         glyph_wdata = BLANK_GLYPH;
         depth_wdata = CLEAR_DEPTH;
      end else if (cmd.glyph_rd) begin
         mem_addr    = idx_addr;
         glyph_wdata = glyph_ff;
         depth_wdata = pz_ff;
      end else begin
         mem_addr    = cell_addr_ff;
         glyph_wdata = glyph_ff;
         depth_wdata = pz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[mem_addr] <= glyph_wdata;
      end
      if (cmd.glyph_rd) begin
         glyph_q_ff <= glyph_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_addr] <= depth_wdata;
      end
      if (cmd.depth_rd) begin
         depth_q_ff <= $signed(depth_mem[mem_addr]);
      end
   end

   // Pending result of the transaction in flight.
   logic               res_written_ff, res_written_in;
   logic [GLYPH_W-1:0] res_glyph_ff, res_glyph_in;

   always_comb begin
      res_written_in = res_written_ff;
      res_glyph_in   = res_glyph_ff;
      if (cmd.load) begin
         res_written_in = 1'b0;
         res_glyph_in   = '0;
      end
      if (hit) begin
         res_written_in = 1'b1;
      end
      if (cmd.glyph_take) begin
         res_glyph_in = idx_ok ? glyph_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      res_written_ff <= res_written_in;
      res_glyph_ff   <= res_glyph_in;
   end

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_written_ff;
   logic [GLYPH_W-1:0] rsp_glyph_ff;

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_written_ff <= res_written_ff;
         rsp_glyph_ff   <= res_glyph_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_written = rsp_written_ff;
   assign rsp_glyph   = rsp_glyph_ff;

   assign status.clear_last = (clr_count_ff == clr_end_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule
